// ===== hw/rtl/usbsrh_pkg.sv =====
// ----------------------------------------------------------------------------
// usbsrh_pkg
// Shared types, codes and the device state table of the standard request
// handler.
// ----------------------------------------------------------------------------
package usbsrh_pkg;

   // default number of endpoint halt slots
   localparam int ENDPOINT_SLOTS_DEFAULT = 16;

   // endpoint_count after reset
   localparam logic [3:0] ENDPOINT_COUNT_RESET = 4'd2;

   // item kinds
   localparam logic [2:0] ACT_SETUP   = 3'd0;
   localparam logic [2:0] ACT_SUSPEND = 3'd1;
   localparam logic [2:0] ACT_RESET   = 3'd2;
   localparam logic [2:0] ACT_RESUME  = 3'd3;
   localparam logic [2:0] ACT_START   = 3'd4;

   // result status codes
   localparam logic [1:0] STS_ACK    = 2'd0;
   localparam logic [1:0] STS_DATA   = 2'd1;
   localparam logic [1:0] STS_STALL  = 2'd2;
   localparam logic [1:0] STS_REJECT = 2'd3;

   // reply sources
   localparam logic [2:0] SRC_INLINE    = 3'd0;
   localparam logic [2:0] SRC_DEVICE    = 3'd1;
   localparam logic [2:0] SRC_CONFIG    = 3'd2;
   localparam logic [2:0] SRC_STRING    = 3'd3;
   localparam logic [2:0] SRC_INTERFACE = 3'd4;
   localparam logic [2:0] SRC_ENDPOINT  = 3'd5;

   // framework device states
   localparam logic [2:0] DEV_POWERED    = 3'd0;
   localparam logic [2:0] DEV_DEFAULT    = 3'd1;
   localparam logic [2:0] DEV_ADDRESS    = 3'd2;
   localparam logic [2:0] DEV_CONFIGURED = 3'd3;
   localparam logic [2:0] DEV_SUSPENDED  = 3'd4;

   // configuration commands
   localparam logic [1:0] CFG_NONE   = 2'd0;
   localparam logic [1:0] CFG_DECONF = 2'd1;
   localparam logic [1:0] CFG_APPLY  = 2'd2;

   // state table events
   localparam logic [2:0] EV_SUSPEND  = 3'd0;
   localparam logic [2:0] EV_RESET    = 3'd1;
   localparam logic [2:0] EV_RESUME   = 3'd2;
   localparam logic [2:0] EV_ADDR     = 3'd3;
   localparam logic [2:0] EV_CONFIG   = 3'd4;
   localparam logic [2:0] EV_DECONFIG = 3'd5;

   // machine states: each framework state with its suspended twin
   localparam logic [2:0] MS_POWERED      = 3'd0;
   localparam logic [2:0] MS_POWERED_SUSP = 3'd1;
   localparam logic [2:0] MS_DEFAULT      = 3'd2;
   localparam logic [2:0] MS_DEFAULT_SUSP = 3'd3;
   localparam logic [2:0] MS_ADDRESS      = 3'd4;
   localparam logic [2:0] MS_ADDRESS_SUSP = 3'd5;
   localparam logic [2:0] MS_CONFIG       = 3'd6;
   localparam logic [2:0] MS_CONFIG_SUSP  = 3'd7;

   // standard request codes
   localparam logic [7:0] REQ_GET_STATUS    = 8'd0;
   localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
   localparam logic [7:0] REQ_SET_FEATURE   = 8'd3;
   localparam logic [7:0] REQ_SET_ADDRESS   = 8'd5;
   localparam logic [7:0] REQ_GET_DESC      = 8'd6;
   localparam logic [7:0] REQ_GET_CONFIG    = 8'd8;
   localparam logic [7:0] REQ_SET_CONFIG    = 8'd9;
   localparam logic [7:0] REQ_GET_IFACE     = 8'd10;
   localparam logic [7:0] REQ_SET_IFACE     = 8'd11;

   // recipients
   localparam logic [4:0] RCP_DEVICE    = 5'd0;
   localparam logic [4:0] RCP_INTERFACE = 5'd1;
   localparam logic [4:0] RCP_ENDPOINT  = 5'd2;

   // descriptor types
   localparam logic [7:0] DT_DEVICE    = 8'd1;
   localparam logic [7:0] DT_CONFIG    = 8'd2;
   localparam logic [7:0] DT_STRING    = 8'd3;
   localparam logic [7:0] DT_INTERFACE = 8'd4;
   localparam logic [7:0] DT_ENDPOINT  = 8'd5;

   localparam logic [6:0] ADDR_MASK = 7'h7f;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  request_type;
      logic [7:0]  request_code;
      logic [15:0] request_value;
      logic [15:0] request_index;
      logic [15:0] request_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  reply_source;
      logic [7:0]  descriptor_index;
      logic [15:0] language_id;
      logic [15:0] transfer_limit;
      logic [15:0] inline_data;
      logic [1:0]  inline_bytes;
      logic [2:0]  device_state;
      logic        state_changed;
      logic        address_strobe;
      logic [6:0]  new_address;
      logic [1:0]  config_command;
   } rsp_type;

   typedef struct packed {
      logic       ok;
      logic [2:0] nx;
   } move_type;

   // device state table lookup
   function automatic move_type machine_move(input logic [2:0] st, input logic [2:0] ev);
      move_type mv;
      mv.ok = 1'b1;
      mv.nx = st;
      if (ev == EV_RESET) begin
         mv.nx = MS_DEFAULT;
      end else begin
         case (st)
            MS_POWERED: begin
               if (ev == EV_SUSPEND) mv.nx = MS_POWERED_SUSP;
               else mv.ok = 1'b0;
            end
            MS_POWERED_SUSP: begin
               if (ev == EV_RESUME) mv.nx = MS_POWERED;
               else mv.ok = 1'b0;
            end
            MS_DEFAULT: begin
               if (ev == EV_SUSPEND) mv.nx = MS_DEFAULT_SUSP;
               else if (ev == EV_RESUME) mv.nx = MS_DEFAULT;
               else if (ev == EV_ADDR) mv.nx = MS_ADDRESS;
               else mv.ok = 1'b0;
            end
            MS_DEFAULT_SUSP: begin
               if (ev == EV_RESUME) mv.nx = MS_DEFAULT;
               else mv.ok = 1'b0;
            end
            MS_ADDRESS: begin
               if (ev == EV_SUSPEND) mv.nx = MS_ADDRESS_SUSP;
               else if (ev == EV_CONFIG) mv.nx = MS_CONFIG;
               else mv.ok = 1'b0;
            end
            MS_ADDRESS_SUSP: begin
               if (ev == EV_RESUME) mv.nx = MS_ADDRESS;
               else mv.ok = 1'b0;
            end
            MS_CONFIG: begin
               if (ev == EV_SUSPEND) mv.nx = MS_CONFIG_SUSP;
               else if (ev == EV_DECONFIG) mv.nx = MS_ADDRESS;
               else mv.ok = 1'b0;
            end
            MS_CONFIG_SUSP: begin
               if (ev == EV_RESUME) mv.nx = MS_CONFIG;
               else mv.ok = 1'b0;
            end
            default: mv.ok = 1'b0;
         endcase
      end
      if (!mv.ok) mv.nx = st;
      return mv;
   endfunction

   // framework device state of a machine state
   function automatic logic [2:0] dev_of(input logic [2:0] st);
      logic [2:0] ds;
      case (st)
         MS_POWERED: ds = DEV_POWERED;
         MS_DEFAULT: ds = DEV_DEFAULT;
         MS_ADDRESS: ds = DEV_ADDRESS;
         MS_CONFIG:  ds = DEV_CONFIGURED;
         default:    ds = DEV_SUSPENDED;
      endcase
      return ds;
   endfunction

endpackage

// ===== hw/rtl/usbsrh_decode.sv =====
// ----------------------------------------------------------------------------
// usbsrh_decode
// Decodes one bus event or setup request against the current device state
// and produces the result and the next state.
// ----------------------------------------------------------------------------
module usbsrh_decode #(
   parameter int ENDPOINT_SLOTS = usbsrh_pkg::ENDPOINT_SLOTS_DEFAULT
) (
   input  usbsrh_pkg::req_type      req_in,
   input  logic [2:0]               machine_state,
   input  logic [6:0]               address,
   input  logic [ENDPOINT_SLOTS-1:0] halt,
   input  logic [3:0]               endpoint_count,
   output usbsrh_pkg::rsp_type      rsp_out,
   output logic [2:0]               machine_next,
   output logic [6:0]               address_next,
   output logic [ENDPOINT_SLOTS-1:0] halt_next
);
   import usbsrh_pkg::*;

   always_comb begin
      move_type   mv;
      logic [2:0] ds;
      logic [4:0] recip;
      logic [3:0] ep;
      logic [7:0] ifc;
      logic [7:0] dtype;
      logic [7:0] dindex;
      logic       ep_bad;
      logic       halt_bit;
      logic       iface_bad;

      mv     = '0;
      ds     = dev_of(machine_state);
      recip  = req_in.request_type[4:0];
      ep     = req_in.request_index[3:0];
      ifc    = req_in.request_index[7:0];
      dtype  = req_in.request_value[15:8];
      dindex = req_in.request_value[7:0];

      // endpoint range and state check
      ep_bad = ((ep != 4'd0) && (ds != DEV_CONFIGURED)) || (ep > endpoint_count)
               || ({1'b0, ep} >= 5'(ENDPOINT_SLOTS));
      halt_bit = 1'b0;
      for (int i = 0; i < ENDPOINT_SLOTS; i++) begin
         if (ep == 4'(i)) halt_bit = halt[i];
      end
      iface_bad = (ds == DEV_DEFAULT) || ((ds == DEV_ADDRESS) && (ifc != 8'd0))
                  || ((ds == DEV_CONFIGURED) && (ifc != 8'd1));

      rsp_out = '0;
      rsp_out.status = STS_STALL;
      machine_next = machine_state;
      address_next = address;
      halt_next    = halt;

      // bus events
      if (req_in.action == ACT_SUSPEND || req_in.action == ACT_RESUME) begin
         mv = machine_move(machine_state,
                           (req_in.action == ACT_SUSPEND) ? EV_SUSPEND : EV_RESUME);
         machine_next = mv.nx;
         rsp_out.status = mv.ok ? STS_ACK : STS_REJECT;
      end else if (req_in.action == ACT_RESET) begin
         mv = machine_move(machine_state, EV_RESET);
         machine_next = mv.nx;
         if (mv.ok) address_next = '0;
         rsp_out.status = mv.ok ? STS_ACK : STS_REJECT;
      end else if (req_in.action == ACT_START) begin
         machine_next = MS_POWERED;
         rsp_out.status = STS_ACK;
      end else if (req_in.action != ACT_SETUP) begin
         rsp_out.status = STS_REJECT;
      end else if (req_in.request_type[6:5] == 2'd0) begin
         // standard requests
         if (recip == RCP_DEVICE) begin
            case (req_in.request_code)
               REQ_GET_STATUS: begin
                  rsp_out.status       = STS_DATA;
                  rsp_out.inline_data  = 16'd1;
                  rsp_out.inline_bytes = 2'd2;
               end
               REQ_SET_ADDRESS: begin
                  if (ds != DEV_CONFIGURED) begin
                     if ((req_in.request_value[6:0] & ADDR_MASK) != 7'd0) begin
                        address_next = req_in.request_value[6:0] & ADDR_MASK;
                        mv = machine_move(machine_state, EV_ADDR);
                        machine_next = mv.nx;
                        rsp_out.address_strobe = 1'b1;
                     end
                     rsp_out.status = STS_ACK;
                  end
               end
               REQ_GET_DESC: begin
                  rsp_out.status = STS_DATA;
                  rsp_out.descriptor_index = dindex;
                  if (dtype == DT_DEVICE) begin
                     rsp_out.reply_source = SRC_DEVICE;
                  end else if (dtype == DT_CONFIG) begin
                     rsp_out.reply_source = SRC_CONFIG;
                  end else if (dtype == DT_STRING) begin
                     rsp_out.reply_source = SRC_STRING;
                     rsp_out.language_id  = req_in.request_index;
                  end else if (dtype == DT_INTERFACE) begin
                     rsp_out.reply_source = SRC_INTERFACE;
                  end else if (dtype == DT_ENDPOINT && dindex >= 8'd1
                               && dindex <= {4'd0, endpoint_count}) begin
                     rsp_out.reply_source = SRC_ENDPOINT;
                  end else begin
                     rsp_out.status = STS_STALL;
                     rsp_out.descriptor_index = '0;
                  end
               end
               REQ_GET_CONFIG: begin
                  rsp_out.status       = STS_DATA;
                  rsp_out.inline_bytes = 2'd1;
                  rsp_out.inline_data  = {15'd0, ds == DEV_CONFIGURED};
               end
               REQ_SET_CONFIG: begin
                  if (ds != DEV_DEFAULT) begin
                     if (req_in.request_value == 16'd0) begin
                        mv = machine_move(machine_state, EV_DECONFIG);
                        machine_next = mv.nx;
                        rsp_out.config_command = CFG_DECONF;
                        rsp_out.status = STS_ACK;
                     end else if (req_in.request_value == 16'd1) begin
                        mv = machine_move(machine_state, EV_CONFIG);
                        machine_next = mv.nx;
                        rsp_out.config_command = CFG_APPLY;
                        rsp_out.status = STS_ACK;
                     end
                  end
               end
               default: rsp_out.status = STS_STALL;
            endcase
         end else if (recip == RCP_INTERFACE) begin
            case (req_in.request_code)
               REQ_GET_STATUS: begin
                  if (!iface_bad) begin
                     rsp_out.status       = STS_DATA;
                     rsp_out.inline_bytes = 2'd2;
                  end
               end
               REQ_GET_IFACE: begin
                  if (ds == DEV_CONFIGURED && ifc == 8'd1) begin
                     rsp_out.status       = STS_DATA;
                     rsp_out.inline_bytes = 2'd1;
                  end
               end
               REQ_SET_IFACE: rsp_out.status = STS_ACK;
               default:       rsp_out.status = STS_STALL;
            endcase
         end else if (recip == RCP_ENDPOINT) begin
            if (req_in.request_code inside {REQ_GET_STATUS, REQ_CLEAR_FEATURE,
                                            REQ_SET_FEATURE} && !ep_bad) begin
               if (req_in.request_code == REQ_GET_STATUS) begin
                  rsp_out.status       = STS_DATA;
                  rsp_out.inline_bytes = 2'd2;
                  rsp_out.inline_data  = {15'd0, halt_bit};
               end else if (req_in.request_value == 16'd0) begin
                  // set or clear the endpoint halt bit
                  for (int i = 0; i < ENDPOINT_SLOTS; i++) begin
                     if (ep == 4'(i))
                        halt_next[i] = (req_in.request_code == REQ_SET_FEATURE);
                  end
                  rsp_out.status = STS_ACK;
               end
            end
         end
      end

      if (rsp_out.status == STS_DATA) rsp_out.transfer_limit = req_in.request_length;
      rsp_out.device_state  = dev_of(machine_next);
      rsp_out.state_changed = (dev_of(machine_next) != ds);
      rsp_out.new_address   = address_next;
   end

endmodule

// ===== hw/rtl/usb_standard_request_handler.sv =====
// ----------------------------------------------------------------------------
// usb_standard_request_handler
// Path: input register, then decode, then result register. Throughput:
// one request or bus event per cycle while the result channel does not
// stall, set by the single input-register to result-register decode stage.
// Reset: device machine goes to powered suspended, address zero, all halt
// bits clear, endpoint_count 2, both pipeline stages empty.
// ----------------------------------------------------------------------------
module usb_standard_request_handler #(
   parameter int ENDPOINT_SLOTS = usbsrh_pkg::ENDPOINT_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_endpoint_count,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_request_type,
   input  logic [7:0]  req_request_code,
   input  logic [15:0] req_request_value,
   input  logic [15:0] req_request_index,
   input  logic [15:0] req_request_length,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_reply_source,
   output logic [7:0]  rsp_descriptor_index,
   output logic [15:0] rsp_language_id,
   output logic [15:0] rsp_transfer_limit,
   output logic [15:0] rsp_inline_data,
   output logic [1:0]  rsp_inline_bytes,
   output logic [2:0]  rsp_device_state,
   output logic        rsp_state_changed,
   output logic        rsp_address_strobe,
   output logic [6:0]  rsp_new_address,
   output logic [1:0]  rsp_config_command
);
   import usbsrh_pkg::*;

   logic                      in_valid_ff;
   req_type                   req_ff;
   logic                      out_valid_ff;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;
   logic [2:0]                machine_ff;
   logic [2:0]                machine_in;
   logic [6:0]                address_ff;
   logic [6:0]                address_in;
   logic [ENDPOINT_SLOTS-1:0] halt_ff;
   logic [ENDPOINT_SLOTS-1:0] halt_in;
   logic [3:0]                epcount_ff;
   logic                      out_load;
   logic                      stage_adv;

   // handshake
   assign stage_adv = !out_valid_ff || rsp_ready;
   assign out_load  = in_valid_ff && stage_adv;
   assign req_ready = !in_valid_ff || stage_adv;
   assign csr_ready = 1'b1;

   // decode
   usbsrh_decode #(
      .ENDPOINT_SLOTS(ENDPOINT_SLOTS)
   ) u_decode (
      .req_in        (req_ff),
      .machine_state (machine_ff),
      .address       (address_ff),
      .halt          (halt_ff),
      .endpoint_count(epcount_ff),
      .rsp_out       (rsp_in),
      .machine_next  (machine_in),
      .address_next  (address_in),
      .halt_next     (halt_in)
   );

   // control and device state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         machine_ff   <= MS_POWERED_SUSP;
         address_ff   <= '0;
         halt_ff      <= '0;
         epcount_ff   <= ENDPOINT_COUNT_RESET;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (stage_adv) out_valid_ff <= in_valid_ff;
         if (out_load) begin
            machine_ff <= machine_in;
            address_ff <= address_in;
            halt_ff    <= halt_in;
         end
         if (csr_valid && csr_ready) epcount_ff <= csr_endpoint_count;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff.action         <= req_action;
         req_ff.request_type   <= req_request_type;
         req_ff.request_code   <= req_request_code;
         req_ff.request_value  <= req_request_value;
         req_ff.request_index  <= req_request_index;
         req_ff.request_length <= req_request_length;
      end
      if (out_load) rsp_ff <= rsp_in;
   end

   // result outputs
   assign rsp_valid            = out_valid_ff;
   assign rsp_status           = rsp_ff.status;
   assign rsp_reply_source     = rsp_ff.reply_source;
   assign rsp_descriptor_index = rsp_ff.descriptor_index;
   assign rsp_language_id      = rsp_ff.language_id;
   assign rsp_transfer_limit   = rsp_ff.transfer_limit;
   assign rsp_inline_data      = rsp_ff.inline_data;
   assign rsp_inline_bytes     = rsp_ff.inline_bytes;
   assign rsp_device_state     = rsp_ff.device_state;
   assign rsp_state_changed    = rsp_ff.state_changed;
   assign rsp_address_strobe   = rsp_ff.address_strobe;
   assign rsp_new_address      = rsp_ff.new_address;
   assign rsp_config_command   = rsp_ff.config_command;

endmodule

// ===== hw/rtl/usbsrh_checker.sv =====
// ----------------------------------------------------------------------------
// usbsrh_checker
// Port-level checks of the standard request handler, bound to the top level.
// ----------------------------------------------------------------------------
module usbsrh_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [2:0]  rsp_reply_source,
   input logic [15:0] rsp_transfer_limit,
   input logic [15:0] rsp_inline_data,
   input logic [1:0]  rsp_inline_bytes,
   input logic        rsp_address_strobe,
   input logic [6:0]  rsp_new_address
);
   import usbsrh_pkg::*;

   // stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result changed while stalled");

   // only data replies carry a source and a byte limit
   a_data_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_DATA |->
         rsp_reply_source == SRC_INLINE && rsp_transfer_limit == 16'd0)
      else $error("non-data result carries data stage fields");

   // no inline bytes means no inline value
   a_inline_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inline_bytes == 2'd0 |-> rsp_inline_data == 16'd0)
      else $error("inline data without inline bytes");

   // an address strobe always applies a nonzero address
   a_strobe_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_address_strobe |-> rsp_new_address != 7'd0 &&
         rsp_status == STS_ACK)
      else $error("address strobe with zero address");

endmodule

bind usb_standard_request_handler usbsrh_checker u_checker (.*);

// ===== test/tb_usb_standard_request_handler.sv =====
// ----------------------------------------------------------------------------
// tb_usb_standard_request_handler
// Self-checking bench for the standard request handler. A short table of
// bus events and setup requests opens the run, then random traffic biased
// toward enumeration follows, under several endpoint counts. A behavioral
// copy of the device state machine, address and halt bits predicts each
// untyped response; all are compared field by field in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_usb_standard_request_handler;
   import usbsrh_pkg::*;

   localparam int SLOTS = ENDPOINT_SLOTS_DEFAULT;
   localparam logic [3:0] NO_MOVE = 4'd8;
   localparam int PHASE_ITEMS = 170;

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } plan_row;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_endpoint_count = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_action = '0;
   logic [7:0]  req_request_type = '0;
   logic [7:0]  req_request_code = '0;
   logic [15:0] req_request_value = '0;
   logic [15:0] req_request_index = '0;
   logic [15:0] req_request_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_reply_source;
   logic [7:0]  rsp_descriptor_index;
   logic [15:0] rsp_language_id;
   logic [15:0] rsp_transfer_limit;
   logic [15:0] rsp_inline_data;
   logic [1:0]  rsp_inline_bytes;
   logic [2:0]  rsp_device_state;
   logic        rsp_state_changed;
   logic        rsp_address_strobe;
   logic [6:0]  rsp_new_address;
   logic [1:0]  rsp_config_command;

   // shadow of the device state
   logic [2:0]  dev_machine = MS_POWERED_SUSP;
   logic [6:0]  dev_address = '0;
   logic [15:0] halt_mask = '0;
   logic [3:0]  ep_count = ENDPOINT_COUNT_RESET;

   rsp_type     pending_responses[$];
   plan_row     plan[$];
   bit          calm = 1'b0;
   int          stall_left = 0;
   int          fail_count = 0;
   int          items_sent = 0;
   int          responses_seen = 0;
   int          configured_seen = 0;
   int          csr_writes = 0;

   usb_standard_request_handler #(
      .ENDPOINT_SLOTS(SLOTS)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_endpoint_count   (csr_endpoint_count),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_request_type     (req_request_type),
      .req_request_code     (req_request_code),
      .req_request_value    (req_request_value),
      .req_request_index    (req_request_index),
      .req_request_length   (req_request_length),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_reply_source     (rsp_reply_source),
      .rsp_descriptor_index (rsp_descriptor_index),
      .rsp_language_id      (rsp_language_id),
      .rsp_transfer_limit   (rsp_transfer_limit),
      .rsp_inline_data      (rsp_inline_data),
      .rsp_inline_bytes     (rsp_inline_bytes),
      .rsp_device_state     (rsp_device_state),
      .rsp_state_changed    (rsp_state_changed),
      .rsp_address_strobe   (rsp_address_strobe),
      .rsp_new_address      (rsp_new_address),
      .rsp_config_command   (rsp_config_command)
   );

   // clock
   always #1 clock = ~clock;

   // device state table, NO_MOVE where the event is not allowed
   function automatic logic [3:0] next_machine(input logic [2:0] ms, input logic [2:0] ev);
      logic [3:0] nx;
      nx = NO_MOVE;
      if (ev == EV_RESET) begin
         nx = {1'b0, MS_DEFAULT};
      end else begin
         case (ms)
            MS_POWERED: begin
               if (ev == EV_SUSPEND) nx = {1'b0, MS_POWERED_SUSP};
            end
            MS_POWERED_SUSP: begin
               if (ev == EV_RESUME) nx = {1'b0, MS_POWERED};
            end
            MS_DEFAULT: begin
               if (ev == EV_SUSPEND) nx = {1'b0, MS_DEFAULT_SUSP};
               else if (ev == EV_RESUME) nx = {1'b0, MS_DEFAULT};
               else if (ev == EV_ADDR) nx = {1'b0, MS_ADDRESS};
            end
            MS_DEFAULT_SUSP: begin
               if (ev == EV_RESUME) nx = {1'b0, MS_DEFAULT};
            end
            MS_ADDRESS: begin
               if (ev == EV_SUSPEND) nx = {1'b0, MS_ADDRESS_SUSP};
               else if (ev == EV_CONFIG) nx = {1'b0, MS_CONFIG};
            end
            MS_ADDRESS_SUSP: begin
               if (ev == EV_RESUME) nx = {1'b0, MS_ADDRESS};
            end
            MS_CONFIG: begin
               if (ev == EV_SUSPEND) nx = {1'b0, MS_CONFIG_SUSP};
               else if (ev == EV_DECONFIG) nx = {1'b0, MS_ADDRESS};
            end
            default: begin
               if (ev == EV_RESUME) nx = {1'b0, MS_CONFIG};
            end
         endcase
      end
      return nx;
   endfunction

   // framework state seen by the host side
   function automatic logic [2:0] framework_state(input logic [2:0] ms);
      case (ms)
         MS_POWERED: return DEV_POWERED;
         MS_DEFAULT: return DEV_DEFAULT;
         MS_ADDRESS: return DEV_ADDRESS;
         MS_CONFIG:  return DEV_CONFIGURED;
         default:    return DEV_SUSPENDED;
      endcase
   endfunction

   // step the shadow machine, report whether the event was allowed
   function automatic bit take_event(input logic [2:0] ev);
      logic [3:0] nx;
      nx = next_machine(dev_machine, ev);
      if (nx == NO_MOVE) return 1'b0;
      dev_machine = nx[2:0];
      return 1'b1;
   endfunction

   function automatic bit endpoint_refused(input logic [3:0] ep);
      if (ep != 4'd0 && framework_state(dev_machine) != DEV_CONFIGURED) return 1'b1;
      if (ep > ep_count) return 1'b1;
      return int'(ep) >= SLOTS;
   endfunction

   // response to one request or bus event, updating the shadow state
   function automatic rsp_type predict_response(input req_type r);
      rsp_type    o;
      logic [2:0] old_ds;
      logic [2:0] ds;
      logic [3:0] ep;
      logic [7:0] ifc;
      logic [6:0] addr;
      o = '0;
      o.status = STS_STALL;
      old_ds = framework_state(dev_machine);
      ds = old_ds;
      ep = r.request_index[3:0];
      ifc = r.request_index[7:0];
      addr = r.request_value[6:0];
      case (r.action)
         ACT_SUSPEND: o.status = take_event(EV_SUSPEND) ? STS_ACK : STS_REJECT;
         ACT_RESUME:  o.status = take_event(EV_RESUME) ? STS_ACK : STS_REJECT;
         ACT_RESET: begin
            if (take_event(EV_RESET)) begin
               dev_address = '0;
               o.status = STS_ACK;
            end else begin
               o.status = STS_REJECT;
            end
         end
         ACT_START: begin
            dev_machine = MS_POWERED;
            o.status = STS_ACK;
         end
         ACT_SETUP: begin
            // only standard requests to device, interface or endpoint
            if (r.request_type[6:5] == 2'b00 && r.request_type[4:0] == RCP_DEVICE) begin
               case (r.request_code)
                  REQ_GET_STATUS: begin
                     o.status = STS_DATA;
                     o.inline_data = 16'd1;
                     o.inline_bytes = 2'd2;
                  end
                  REQ_SET_ADDRESS: begin
                     if (ds != DEV_CONFIGURED) begin
                        if (addr != 7'd0) begin
                           dev_address = addr;
                           void'(take_event(EV_ADDR));
                           o.address_strobe = 1'b1;
                        end
                        o.status = STS_ACK;
                     end
                  end
                  REQ_GET_DESC: begin
                     o.descriptor_index = r.request_value[7:0];
                     o.status = STS_DATA;
                     case (r.request_value[15:8])
                        DT_DEVICE:    o.reply_source = SRC_DEVICE;
                        DT_CONFIG:    o.reply_source = SRC_CONFIG;
                        DT_STRING: begin
                           o.reply_source = SRC_STRING;
                           o.language_id = r.request_index;
                        end
                        DT_INTERFACE: o.reply_source = SRC_INTERFACE;
                        default: begin
                           if (r.request_value[15:8] == DT_ENDPOINT &&
                               r.request_value[7:0] >= 8'd1 &&
                               r.request_value[7:0] <= {4'd0, ep_count}) begin
                              o.reply_source = SRC_ENDPOINT;
                           end else begin
                              o.status = STS_STALL;
                              o.descriptor_index = '0;
                           end
                        end
                     endcase
                  end
                  REQ_GET_CONFIG: begin
                     o.status = STS_DATA;
                     o.inline_bytes = 2'd1;
                     o.inline_data = (ds == DEV_CONFIGURED) ? 16'd1 : 16'd0;
                  end
                  REQ_SET_CONFIG: begin
                     // command goes out even when the state table refuses
                     if (ds != DEV_DEFAULT) begin
                        if (r.request_value == 16'd0) begin
                           void'(take_event(EV_DECONFIG));
                           o.config_command = CFG_DECONF;
                           o.status = STS_ACK;
                        end else if (r.request_value == 16'd1) begin
                           void'(take_event(EV_CONFIG));
                           o.config_command = CFG_APPLY;
                           o.status = STS_ACK;
                        end
                     end
                  end
                  default: o.status = STS_STALL;
               endcase
            end else if (r.request_type[6:5] == 2'b00 &&
                         r.request_type[4:0] == RCP_INTERFACE) begin
               case (r.request_code)
                  REQ_GET_STATUS: begin
                     if (!(ds == DEV_DEFAULT || (ds == DEV_ADDRESS && ifc != 8'd0) ||
                           (ds == DEV_CONFIGURED && ifc != 8'd1))) begin
                        o.status = STS_DATA;
                        o.inline_bytes = 2'd2;
                     end
                  end
                  REQ_GET_IFACE: begin
                     if (ds == DEV_CONFIGURED && ifc == 8'd1) begin
                        o.status = STS_DATA;
                        o.inline_bytes = 2'd1;
                     end
                  end
                  REQ_SET_IFACE: o.status = STS_ACK;
                  default: o.status = STS_STALL;
               endcase
            end else if (r.request_type[6:5] == 2'b00 &&
                         r.request_type[4:0] == RCP_ENDPOINT) begin
               if ((r.request_code == REQ_GET_STATUS || r.request_code == REQ_CLEAR_FEATURE ||
                    r.request_code == REQ_SET_FEATURE) && !endpoint_refused(ep)) begin
                  if (r.request_code == REQ_GET_STATUS) begin
                     o.status = STS_DATA;
                     o.inline_bytes = 2'd2;
                     o.inline_data = {15'd0, halt_mask[ep]};
                  end else if (r.request_value == 16'd0) begin
                     // only the halt feature exists
                     halt_mask[ep] = (r.request_code == REQ_SET_FEATURE);
                     o.status = STS_ACK;
                  end
               end
            end
         end
         default: o.status = STS_REJECT;
      endcase
      if (o.status == STS_DATA) o.transfer_limit = r.request_length;
      o.device_state = framework_state(dev_machine);
      o.state_changed = (o.device_state != old_ds);
      o.new_address = dev_address;
      return o;
   endfunction

   function automatic req_type setup_req(input logic [7:0] rt, input logic [7:0] code,
                                         input logic [15:0] val, input logic [15:0] idx,
                                         input logic [15:0] len);
      req_type r;
      r.action = ACT_SETUP;
      r.request_type = rt;
      r.request_code = code;
      r.request_value = val;
      r.request_index = idx;
      r.request_length = len;
      return r;
   endfunction

   // bus event with junk in the setup fields
   function automatic req_type bus_event(input logic [2:0] act);
      req_type r;
      r = setup_req(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
      r.action = act;
      return r;
   endfunction

   function automatic rsp_type quiet_result(input logic [1:0] st, input logic [2:0] ds,
                                            input logic chg, input logic strobe,
                                            input logic [6:0] addr);
      rsp_type o;
      o = '0;
      o.status = st;
      o.device_state = ds;
      o.state_changed = chg;
      o.address_strobe = strobe;
      o.new_address = addr;
      return o;
   endfunction

   task automatic add_row(input req_type it, input logic typed, input rsp_type want);
      plan_row p;
      p.item = it;
      p.typed = typed;
      p.want = want;
      plan.push_back(p);
   endtask

   // random item, mostly standard requests, often the next enumeration step
   function automatic req_type pick_item();
      req_type    r;
      logic [2:0] ds;
      int         roll;
      r = bus_event(3'($urandom));
      ds = framework_state(dev_machine);
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         return r;
      end else if (roll < 30) begin
         r.action = 3'($urandom_range(1, 4));
         if ($urandom_range(0, 15) == 0) r.action = 3'($urandom_range(5, 7));
         return r;
      end
      r.action = ACT_SETUP;
      r.request_type[6:0] = {2'b00, 5'($urandom_range(0, 2))};
      if ($urandom_range(0, 15) == 0) r.request_type[4:0] = 5'($urandom);
      if (roll < 48 && ds != DEV_CONFIGURED) begin
         case (ds)
            DEV_SUSPENDED: r.action = ACT_RESUME;
            DEV_POWERED:   r.action = ACT_RESET;
            DEV_DEFAULT: begin
               r.request_type[4:0] = RCP_DEVICE;
               r.request_code = REQ_SET_ADDRESS;
            end
            default: begin
               r.request_type[4:0] = RCP_DEVICE;
               r.request_code = REQ_SET_CONFIG;
               r.request_value = 16'd1;
            end
         endcase
         return r;
      end
      case ($urandom_range(0, 8))
         0: r.request_code = REQ_GET_STATUS;
         1: r.request_code = REQ_CLEAR_FEATURE;
         2: r.request_code = REQ_SET_FEATURE;
         3: r.request_code = REQ_SET_ADDRESS;
         4: r.request_code = REQ_GET_DESC;
         5: r.request_code = REQ_GET_CONFIG;
         6: r.request_code = REQ_SET_CONFIG;
         7: r.request_code = REQ_GET_IFACE;
         default: r.request_code = REQ_SET_IFACE;
      endcase
      case ($urandom_range(0, 2))
         0: r.request_value = 16'($urandom_range(0, 2));
         1: begin
            r.request_value[15:8] = 8'($urandom_range(0, 6));
            r.request_value[7:0] = 8'($urandom_range(0, 16));
         end
         default: r.request_value = 16'($urandom);
      endcase
      if ($urandom_range(0, 2) != 0) r.request_index = 16'($urandom_range(0, 17));
      return r;
   endfunction

   // one transfer on the request channel, expectation queued on acceptance
   task automatic send_item(input req_type it, input logic typed, input rsp_type want);
      int      gap;
      rsp_type guess;
      gap = 0;
      if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= it.action;
      req_request_type <= it.request_type;
      req_request_code <= it.request_code;
      req_request_value <= it.request_value;
      req_request_index <= it.request_index;
      req_request_length <= it.request_length;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      guess = predict_response(it);
      pending_responses.push_back(typed ? want : guess);
      items_sent++;
   endtask

   // drop valid and let every outstanding response come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_endpoint_count(input logic [3:0] cnt);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_endpoint_count <= cnt;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      ep_count = cnt;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver stalls in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got = {rsp_status, rsp_reply_source, rsp_descriptor_index, rsp_language_id,
                rsp_transfer_limit, rsp_inline_data, rsp_inline_bytes, rsp_device_state,
                rsp_state_changed, rsp_address_strobe, rsp_new_address, rsp_config_command};
         if (pending_responses.size() == 0) begin
            $display("%0t: response with nothing pending, status %h", $time, got.status);
            fail_count++;
         end else begin
            want = pending_responses.pop_front();
            responses_seen++;
            if (got.device_state == DEV_CONFIGURED) configured_seen++;
            check_field("status", 16'(want.status), 16'(got.status));
            check_field("reply_source", 16'(want.reply_source), 16'(got.reply_source));
            check_field("descriptor_index", 16'(want.descriptor_index),
                        16'(got.descriptor_index));
            check_field("language_id", want.language_id, got.language_id);
            check_field("transfer_limit", want.transfer_limit, got.transfer_limit);
            check_field("inline_data", want.inline_data, got.inline_data);
            check_field("inline_bytes", 16'(want.inline_bytes), 16'(got.inline_bytes));
            check_field("device_state", 16'(want.device_state), 16'(got.device_state));
            check_field("state_changed", 16'(want.state_changed), 16'(got.state_changed));
            check_field("address_strobe", 16'(want.address_strobe),
                        16'(got.address_strobe));
            check_field("new_address", 16'(want.new_address), 16'(got.new_address));
            check_field("config_command", 16'(want.config_command),
                        16'(got.config_command));
         end
      end
   end

   // watchdog
   initial begin
      #400000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      rsp_type want;
      req_type it;
      logic [3:0] cnt;

      // directed table, starting from powered suspended at address zero
      add_row(bus_event(ACT_RESUME), 1'b1,
              quiet_result(STS_ACK, DEV_POWERED, 1'b1, 1'b0, 7'd0));
      add_row(bus_event(ACT_RESUME), 1'b1,
              quiet_result(STS_REJECT, DEV_POWERED, 1'b0, 1'b0, 7'd0));
      add_row(bus_event(3'd7), 1'b1,
              quiet_result(STS_REJECT, DEV_POWERED, 1'b0, 1'b0, 7'd0));
      add_row(setup_req(8'h40, REQ_GET_STATUS, 16'd0, 16'd0, 16'd2), 1'b1,
              quiet_result(STS_STALL, DEV_POWERED, 1'b0, 1'b0, 7'd0));
      add_row(bus_event(ACT_RESET), 1'b1,
              quiet_result(STS_ACK, DEV_DEFAULT, 1'b1, 1'b0, 7'd0));
      // bus reset while already in default stays there
      add_row(bus_event(ACT_RESET), 1'b1,
              quiet_result(STS_ACK, DEV_DEFAULT, 1'b0, 1'b0, 7'd0));
      want = quiet_result(STS_DATA, DEV_DEFAULT, 1'b0, 1'b0, 7'd0);
      want.transfer_limit = 16'hffff;
      want.inline_data = 16'd1;
      want.inline_bytes = 2'd2;
      add_row(setup_req(8'h80, REQ_GET_STATUS, 16'd0, 16'd0, 16'hffff), 1'b1, want);
      add_row(setup_req(8'h00, REQ_SET_CONFIG, 16'd1, 16'd0, 16'd0), 1'b1,
              quiet_result(STS_STALL, DEV_DEFAULT, 1'b0, 1'b0, 7'd0));
      add_row(setup_req(8'h00, REQ_SET_ADDRESS, 16'd0, 16'd0, 16'd0), 1'b1,
              quiet_result(STS_ACK, DEV_DEFAULT, 1'b0, 1'b0, 7'd0));
      add_row(setup_req(8'h00, REQ_SET_ADDRESS, 16'hffff, 16'hffff, 16'd0), 1'b1,
              quiet_result(STS_ACK, DEV_ADDRESS, 1'b1, 1'b1, 7'h7f));
      want = '0;
      add_row(setup_req(8'h80, REQ_GET_DESC, 16'h0100, 16'd0, 16'd18), 1'b0, want);
      add_row(setup_req(8'h80, REQ_GET_DESC, 16'h03ff, 16'h0409, 16'd255), 1'b0, want);
      add_row(setup_req(8'h80, REQ_GET_DESC, 16'h0502, 16'd0, 16'd7), 1'b0, want);
      add_row(setup_req(8'h80, REQ_GET_DESC, 16'h0503, 16'd0, 16'd7), 1'b0, want);
      add_row(setup_req(8'h80, REQ_GET_DESC, 16'h00ff, 16'd0, 16'd7), 1'b0, want);
      add_row(setup_req(8'h80, REQ_GET_CONFIG, 16'd0, 16'd0, 16'd1), 1'b0, want);
      add_row(setup_req(8'h81, REQ_GET_STATUS, 16'd0, 16'd0, 16'd2), 1'b0, want);
      add_row(setup_req(8'h82, REQ_GET_STATUS, 16'd0, 16'd1, 16'd2), 1'b0, want);
      add_row(setup_req(8'h00, REQ_SET_CONFIG, 16'd1, 16'd0, 16'd0), 1'b0, want);
      add_row(setup_req(8'h02, REQ_SET_FEATURE, 16'd0, 16'h0082, 16'd0), 1'b0, want);
      add_row(setup_req(8'h82, REQ_GET_STATUS, 16'd0, 16'h0082, 16'd2), 1'b0, want);
      add_row(setup_req(8'h02, REQ_SET_FEATURE, 16'd0, 16'd3, 16'd0), 1'b0, want);
      add_row(setup_req(8'h02, REQ_CLEAR_FEATURE, 16'd1, 16'd2, 16'd0), 1'b0, want);
      add_row(setup_req(8'h81, REQ_GET_IFACE, 16'd0, 16'd1, 16'd1), 1'b0, want);
      add_row(setup_req(8'h00, REQ_SET_CONFIG, 16'd0, 16'd0, 16'd0), 1'b0, want);
      add_row(bus_event(ACT_SUSPEND), 1'b0, want);
      // start forces powered and keeps the address
      add_row(bus_event(ACT_START), 1'b1,
              quiet_result(STS_ACK, DEV_POWERED, 1'b1, 1'b0, 7'h7f));

      // reset
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].want);
      drain();

      // random traffic under several endpoint counts, the last one without idling
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: cnt = 4'd15;
            1: cnt = 4'd0;
            2: cnt = 4'($urandom_range(1, 14));
            default: cnt = ENDPOINT_COUNT_RESET;
         endcase
         write_endpoint_count(cnt);
         if (phase == 3) calm = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            it = pick_item();
            send_item(it, 1'b0, want);
         end
         drain();
      end

      $display("%0d requests and bus events over %0d endpoint count writes,", items_sent,
               csr_writes);
      $display("%0d responses checked, %0d of them in configured state", responses_seen,
               configured_seen);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/usbsrh_pkg.sv
hw/rtl/usbsrh_decode.sv
hw/rtl/usb_standard_request_handler.sv
hw/rtl/usbsrh_checker.sv
test/tb_usb_standard_request_handler.sv
